>>> src/ble_pkg.sv
// Shared types and codes for the bounded list engine.
package ble_pkg;

    // Widths of the input item fields.
    localparam int MODE_W    = 3;
    localparam int OPERAND_W = 32;

    // Operation codes carried in the input item's mode field.
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RMALL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RMPRED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_FLUSH,
        S_DONE
    } t_state;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;  // every cell takes its upper neighbor's value
        logic load;   // the addressed cell takes the load value instead
    } t_cell_ctl;

endpackage

>>> src/ble_cell.sv
// One storage cell of the entry chain: shifts toward the head or loads when addressed.
module ble_cell #(
    parameter int W     = 32,
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  ble_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]     i_load_idx,
    input  logic [W-1:0]      i_load_data,
    input  logic [W-1:0]      i_next,
    output logic [W-1:0]      o_data
);
    import ble_pkg::*;

    logic [W-1:0] r_data;
    logic         w_hit;

    assign w_hit  = i_ctl.load && (i_load_idx == IW'(INDEX));
    assign o_data = r_data;

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

endmodule

>>> src/bounded_list_engine.sv
// Top level of the bounded list engine: controller, result register and the cell chain.
//
//  channel    dir  handshake                        payload
//  ---------  ---  -------------------------------  ----------------------------------------
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready  tuser: mode; tdata: operand
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready  tdata: found, position, length, dropped
//
//  Steps: append, clear and unknown modes take the engine through accept, start and done;
//  the result is registered in the done state once the result register is free. Remove-all
//  and find walk all n entries before done, remove-predecessor (n >= 2) walks them and then
//  flushes, n being the entry count: the walk pops one entry per cycle off the head cell.
//  One item is in work at a time; a new item is taken as soon as the previous one has
//  reached the result register, even while that result still waits on i_m_axis_tready.
//  Reset (synchronous, active low) empties the list and the result register; the cell
//  contents are left as they are and are never read before being written.
module bounded_list_engine #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32,
    localparam int IW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,  // entry index / position
    localparam int CW          = $clog2(DEPTH + 1),                // entry count / length
    localparam int OUT_BITS    = 2 + IW + CW,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,   // [31:0] operand (signed)
    input  logic [7:0]                  i_s_axis_tuser,   // [2:0] mode, upper bits zero
    // result items
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata    // found, position, length, dropped
);
    import ble_pkg::*;

    // ---------------------------------------------------------------- registers
    t_state                  r_state, n_state;
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic [VALUE_BITS-1:0]   r_v, n_v;          // operand, sign-extended to VALUE_BITS
    logic [CW-1:0]           r_cnt, n_cnt;      // cells in use (unvisited + committed)
    logic [IW-1:0]           r_idx, n_idx;      // original index of the entry at the head
    logic [IW-1:0]           r_last_idx, n_last_idx;
    logic [CW-1:0]           r_left, n_left;    // survivors during remove-predecessor
    logic                    r_kill, n_kill;    // head matched: the tail is to be dropped
    logic [VALUE_BITS-1:0]   r_pend, n_pend;    // previous survivor, not yet committed
    logic                    r_pend_v, n_pend_v;
    logic                    r_found, n_found;
    logic [IW-1:0]           r_pos, n_pos;
    logic                    r_dropped, n_dropped;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    // ---------------------------------------------------------------- chain wiring
    t_cell_ctl               w_ctl;
    logic [IW-1:0]           w_load_idx;
    logic [VALUE_BITS-1:0]   w_load_data;
    logic [VALUE_BITS-1:0]   w_cell [DEPTH];

    logic [VALUE_BITS-1:0]   w_head;
    logic [VALUE_BITS-1:0]   w_opv;
    logic                    w_eq;
    logic                    w_last;
    logic                    w_rm;
    logic [CW-1:0]           w_cnt_m1;
    logic                    w_in_acc;
    logic                    w_out_free;

    assign w_head     = w_cell[0];
    assign w_opv      = VALUE_BITS'($signed(i_s_axis_tdata[OPERAND_W-1:0]));
    assign w_eq       = (w_head == r_v);
    assign w_last     = (r_idx == r_last_idx);
    assign w_rm       = w_eq && (r_left > CW'(1));
    assign w_cnt_m1   = r_cnt - CW'(1);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Row of cells; cell 0 is the head. A shift moves every entry one cell toward the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ble_cell #(
            .W     (VALUE_BITS),
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_load_idx  (w_load_idx),
            .i_load_data (w_load_data),
            .i_next      (w_cell[(g + 1) % DEPTH]),
            .o_data      (w_cell[g])
        );
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_START;
            end
            S_START: begin
                n_state = S_DONE;
                if (((r_mode == MODE_RMALL) || (r_mode == MODE_FIND)) && (r_cnt != '0))
                    n_state = S_WALK;
                if ((r_mode == MODE_RMPRED) && (r_cnt > CW'(1)))
                    n_state = S_WALK;
            end
            S_WALK: begin
                if (w_last) n_state = (r_mode == MODE_RMPRED) ? S_FLUSH : S_DONE;
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs / datapath
    // The walk pops the head each cycle; a kept value is written behind the last cell in use
    // (index cnt-1 after the shift), so survivors come out packed and in order.
    always_comb begin
        w_ctl       = '0;
        w_load_idx  = w_cnt_m1[IW-1:0];
        w_load_data = w_head;
        n_mode      = r_mode;
        n_v         = r_v;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_left      = r_left;
        n_kill      = r_kill;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_found     = r_found;
        n_pos       = r_pos;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode = i_s_axis_tuser[MODE_W-1:0];
                    n_v    = w_opv;
                end
            end
            S_START: begin
                n_found    = 1'b0;
                n_pos      = '0;
                n_dropped  = 1'b0;
                n_idx      = '0;
                n_last_idx = w_cnt_m1[IW-1:0];
                n_left     = r_cnt;
                n_kill     = 1'b0;
                n_pend_v   = 1'b0;
                unique case (r_mode)
                    MODE_APPEND: begin
                        if (r_cnt < CW'(DEPTH)) begin
                            w_ctl.load  = 1'b1;
                            w_load_idx  = r_cnt[IW-1:0];
                            w_load_data = r_v;
                            n_cnt       = r_cnt + CW'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                    MODE_CLEAR: n_cnt = '0;
                    default: ;
                endcase
            end
            S_WALK: begin
                w_ctl.shift = 1'b1;
                n_idx       = r_idx + IW'(1);
                unique case (r_mode)
                    MODE_RMALL: begin
                        if (w_eq) n_cnt = w_cnt_m1;
                        else      w_ctl.load = 1'b1;
                    end
                    MODE_FIND: begin
                        w_ctl.load = 1'b1;
                        if (!r_found && w_eq) begin
                            n_found = 1'b1;
                            n_pos   = r_idx;
                        end
                    end
                    MODE_RMPRED: begin
                        w_load_data = r_pend;
                        if (r_kill && w_last) begin
                            // tail already taken out by the head's match
                            n_cnt = w_cnt_m1;
                        end else begin
                            if (r_idx == '0) begin
                                n_cnt = w_cnt_m1;   // head is held back as pending
                                if (w_rm) begin
                                    n_kill = 1'b1;
                                    n_left = r_left - CW'(1);
                                end
                            end else if (w_rm) begin
                                n_cnt  = w_cnt_m1;  // drop the pending predecessor
                                n_left = r_left - CW'(1);
                            end else begin
                                w_ctl.load = 1'b1;  // commit the pending predecessor
                            end
                            n_pend   = w_head;
                            n_pend_v = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_FLUSH: begin
                // last survivor goes behind the committed entries
                w_ctl.load  = 1'b1;
                w_load_idx  = r_cnt[IW-1:0];
                w_load_data = r_pend;
                n_cnt       = r_cnt + CW'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_dropped, r_cnt, r_pos, r_found});
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_v        <= n_v;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_left     <= n_left;
        r_kill     <= n_kill;
        r_pend     <= n_pend;
        r_pend_v   <= n_pend_v;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_dropped  <= n_dropped;
        r_out_data <= n_out_data;
    end

    // ---------------------------------------------------------------- assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above DEPTH");

    a_walk_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_cnt <= $past(r_cnt)))
        else $error("walk step grew the list");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_pend_v)
        else $error("flush without a pending survivor");

    a_keep_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_mode == MODE_RMPRED) |-> (r_left != '0))
        else $error("remove-predecessor emptied the list");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && r_mode == MODE_CLEAR) |=> (r_cnt == '0))
        else $error("clear left entries");

endmodule

>>> bench/tb_bounded_list_engine.sv
// Self-checking testbench for the bounded list engine: directed table, then random traffic.
module tb_bounded_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ble_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 660;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 80;    // longer than the longest remove-predecessor walk

    // One result item as it leaves the block.
    typedef struct packed {
        logic       found;
        logic [5:0] position;
        logic [6:0] length;
        logic       dropped;
    } t_list_result;

    // One row of the directed table.
    typedef struct {
        logic [2:0]   mode;
        logic [31:0]  operand;
        int           reps;
        bit           typed;      // expectation typed in below instead of predicted
        t_list_result typed_res;
    } t_list_cmd;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [31:0] operand (signed)
    logic [7:0]  i_s_axis_tuser  = '0;   // [2:0] mode, [7:3] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [0] found, [6:1] position, [13:7] length, [14] dropped

    bounded_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the list, kept packed from the head.
    logic [31:0]  shadow_list [LIST_DEPTH];
    int           shadow_len = 0;

    t_list_result pending_results [$];
    t_list_cmd    directed_rows [$];
    int           fault_count = 0;
    bit           calm = 1'b0;   // both sides run without gaps while set

    function automatic t_list_result outcome(logic found, int position, int length,
                                             logic dropped);
        t_list_result r;
        r.found    = found;
        r.position = position[5:0];
        r.length   = length[6:0];
        r.dropped  = dropped;
        return r;
    endfunction

    // Applies one operation to the shadow list and returns the result it yields.
    function automatic t_list_result list_apply(logic [2:0] mode, logic [31:0] operand);
        t_list_result r;
        bit           keep [LIST_DEPTH];
        int           n;
        int           left;
        int           p;
        int           w;
        r = '0;
        n = shadow_len;
        for (int i = 0; i < LIST_DEPTH; i++) keep[i] = 1'b1;
        case (mode)
            MODE_APPEND: begin
                if (n < LIST_DEPTH) begin
                    shadow_list[n] = operand;
                    shadow_len     = n + 1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            MODE_RMALL: begin
                for (int i = 0; i < n; i++) keep[i] = (shadow_list[i] != operand);
            end
            MODE_RMPRED: begin
                // visit original entries head first; drop the nearest live predecessor,
                // wrapping from head to tail, but never the last survivor
                left = n;
                if (n >= 2) begin
                    for (int i = 0; i < n; i++) begin
                        if (keep[i] && shadow_list[i] == operand && left > 1) begin
                            p = i;
                            do p = (p == 0) ? n - 1 : p - 1; while (!keep[p] && p != i);
                            if (p != i) begin
                                keep[p] = 1'b0;
                                left--;
                            end
                        end
                    end
                end
            end
            MODE_FIND: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (shadow_list[i] == operand) begin
                        r.found    = 1'b1;
                        r.position = i[5:0];
                    end
                end
            end
            MODE_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
            end
        endcase
        if (mode == MODE_RMALL || mode == MODE_RMPRED) begin
            w = 0;
            for (int i = 0; i < n; i++) begin
                if (keep[i]) begin
                    shadow_list[w] = shadow_list[i];
                    w++;
                end
            end
            shadow_len = w;
        end
        r.length = shadow_len[6:0];
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Small pool so that matches are common; extremes included; some fully random.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 4) == 0) return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h0000_0005;
        endcase
    endfunction

    // Presents one item, waits for its handshake and files the expected result.
    // Returns at the accepting edge with tvalid still high.
    task automatic send_item(logic [2:0] mode, logic [31:0] operand, bit typed,
                             t_list_result typed_res);
        int           gap;
        t_list_result predicted;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= operand;
        i_s_axis_tuser  <= {5'b0, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = list_apply(mode, operand);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    // Sender stops until every outstanding result has come back.
    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(logic [2:0] mode, logic [31:0] operand, int reps, bit typed,
                           t_list_result typed_res);
        t_list_cmd row;
        row.mode      = mode;
        row.operand   = operand;
        row.reps      = reps;
        row.typed     = typed;
        row.typed_res = typed_res;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic log_fault(string what, t_list_result want, t_list_result got);
        fault_count++;
        if (fault_count <= 10)
            $display("MISMATCH %s: expected found=%0d pos=%0d len=%0d drop=%0d,", what,
                     want.found, want.position, want.length, want.dropped,
                     " got found=%0d pos=%0d len=%0d drop=%0d",
                     got.found, got.position, got.length, got.dropped);
    endtask

    // Result side: random back-pressure, calm stretches run it wide open.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.found    = o_m_axis_tdata[0];
            got.position = o_m_axis_tdata[6:1];
            got.length   = o_m_axis_tdata[13:7];
            got.dropped  = o_m_axis_tdata[14];
            if (pending_results.size() == 0) begin
                log_fault("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.position !== want.position ||
                    got.length !== want.length || got.dropped !== want.dropped)
                    log_fault("result fields", want, got);
            end
        end
    end

    // Watchdog: too long with nothing moving on either side means a hang.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bounded_list_engine regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          random_sent;
        int          sel;
        int          burst;
        logic [2:0]  mode;
        logic [31:0] operand;

        // empty list: every lookup and removal is a no-op
        add_row(MODE_FIND,   32'h0000_0000, 1, 1, outcome(0, 0, 0, 0));
        add_row(MODE_RMALL,  32'h0000_0005, 1, 1, outcome(0, 0, 0, 0));
        add_row(MODE_RMPRED, 32'h0000_0005, 1, 1, outcome(0, 0, 0, 0));
        add_row(MODE_CLEAR,  32'h0000_0000, 1, 1, outcome(0, 0, 0, 0));
        // single entry: remove-predecessor must keep the last one
        add_row(MODE_APPEND, 32'h8000_0000, 1, 1, outcome(0, 0, 1, 0));
        add_row(MODE_RMPRED, 32'h8000_0000, 1, 1, outcome(0, 0, 1, 0));
        add_row(MODE_APPEND, 32'h7FFF_FFFF, 1, 1, outcome(0, 0, 2, 0));
        add_row(MODE_FIND,   32'h7FFF_FFFF, 1, 1, outcome(1, 1, 2, 0));
        add_row(MODE_FIND,   32'h8000_0000, 1, 1, outcome(1, 0, 2, 0));
        add_row(MODE_FIND,   32'hFFFF_FFFF, 1, 1, outcome(0, 0, 2, 0));
        add_row(MODE_APPEND, 32'hFFFF_FFFF, 1, 1, outcome(0, 0, 3, 0));
        add_row(MODE_APPEND, 32'hFFFF_FFFF, 1, 1, outcome(0, 0, 4, 0));
        // adjacent matches: second match sees the already shrunk neighborhood
        add_row(MODE_RMPRED, 32'hFFFF_FFFF, 1, 0, '0);
        add_row(MODE_APPEND, 32'h8000_0000, 1, 0, '0);
        // remove-all that takes out the head too
        add_row(MODE_RMALL,  32'h8000_0000, 1, 0, '0);
        // undefined modes only report the length
        add_row(3'd5,        32'h7FFF_FFFF, 1, 0, '0);
        add_row(3'd6,        32'h0000_0000, 1, 0, '0);
        add_row(3'd7,        32'hFFFF_FFFF, 1, 0, '0);
        add_row(MODE_CLEAR,  32'h1234_5678, 1, 1, outcome(0, 0, 0, 0));
        // all equal: predecessor of the head is the tail
        add_row(MODE_APPEND, 32'h0000_0000, 3, 0, '0);
        add_row(MODE_RMPRED, 32'h0000_0000, 1, 0, '0);
        // fill to the brim, then overflow
        add_row(MODE_APPEND, 32'h5A5A_5A5A, LIST_DEPTH - 1, 0, '0);
        add_row(MODE_APPEND, 32'h0000_0001, 1, 1, outcome(0, 0, 64, 1));
        add_row(MODE_FIND,   32'h0000_0001, 1, 1, outcome(0, 0, 64, 0));
        add_row(MODE_FIND,   32'h5A5A_5A5A, 1, 1, outcome(1, 1, 64, 0));
        add_row(MODE_RMPRED, 32'h5A5A_5A5A, 1, 0, '0);
        add_row(MODE_CLEAR,  32'h0000_0000, 1, 1, outcome(0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].mode, directed_rows[r].operand,
                          directed_rows[r].typed, directed_rows[r].typed_res);
        hold_until_drained();

        // Random traffic: mostly appends so the list grows, with append bursts that
        // reach the full store, and match operands often taken from the list itself.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 79) == 0) calm = !calm;
            if ($urandom_range(0, 59) == 0) hold_until_drained();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                burst = $urandom_range(20, 70);
                repeat (burst) send_item(MODE_APPEND, pick_value(), 0, '0);
                random_sent += burst;
            end else begin
                if (sel < 50)      mode = MODE_APPEND;
                else if (sel < 60) mode = MODE_RMALL;
                else if (sel < 73) mode = MODE_RMPRED;
                else if (sel < 91) mode = MODE_FIND;
                else if (sel < 95) mode = MODE_CLEAR;
                else               mode = 3'($urandom_range(5, 7));
                operand = pick_value();
                if (mode != MODE_APPEND && shadow_len > 0 && $urandom_range(0, 1) == 0)
                    operand = shadow_list[$urandom_range(0, shadow_len - 1)];
                send_item(mode, operand, 0, '0);
                random_sent++;
            end
        end

        // Let everything drain, then watch a while for stray results.
        calm = 1'b0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("bounded_list_engine regression: pass");
        end else begin
            $display("bounded_list_engine regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/ble_pkg.sv
src/ble_cell.sv
src/bounded_list_engine.sv
bench/tb_bounded_list_engine.sv
